[hw/rtl/clebuf_pkg.sv]
// shared types and key codes for the cursor line edit buffer
`default_nettype none

package clebuf_pkg;

  localparam logic       OP_KEY    = 1'b0;
  localparam logic       OP_FLUSH  = 1'b1;

  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;
  localparam logic [7:0] KEY_BACK  = 8'h2D;

  typedef struct packed {
    logic       op;
    logic [7:0] key_code;
  } key_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic       last;
    logic       overflowed;
  } char_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_FLUSH
  } clebuf_state_t;

endpackage

`default_nettype wire

[hw/rtl/clebuf_key_if.sv]
// valid/ready channel carrying key items
`default_nettype none

interface clebuf_key_if;
  logic                  valid;
  logic                  ready;
  clebuf_pkg::key_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/clebuf_char_if.sv]
// valid/ready channel carrying line characters
`default_nettype none

interface clebuf_char_if;
  logic                   valid;
  logic                   ready;
  clebuf_pkg::char_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/clebuf_gap_map.sv]
// gap buffer address mapping: head text at the bottom, tail text at the top of the store
`default_nettype none

module clebuf_gap_map #(
  parameter int LINE_CAPACITY = 64,
  localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1,
  localparam int CW = $clog2(LINE_CAPACITY + 1)
) (
  input  logic [CW-1:0] len,
  input  logic [CW-1:0] cur,
  input  logic [CW-1:0] idx,
  output logic [AW-1:0] left_src,
  output logic [AW-1:0] left_dst,
  output logic [AW-1:0] right_src,
  output logic [AW-1:0] right_dst,
  output logic [AW-1:0] flush_addr
);

  logic [CW-1:0] tail;
  logic [CW-1:0] gap_end;
  logic [CW-1:0] cur_dec;
  logic [CW-1:0] gap_dec;
  logic [CW-1:0] flush_full;

  // characters after the cursor sit in the top tail entries
  assign tail    = len - cur;
  assign gap_end = CW'(LINE_CAPACITY) - tail;
  assign cur_dec = cur - CW'(1);
  assign gap_dec = gap_end - CW'(1);

  always_comb begin
    if (idx < cur) begin
      flush_full = idx;
    end else begin
      flush_full = idx + gap_end - cur;
    end
  end

  assign left_src   = cur_dec[AW-1:0];
  assign left_dst   = gap_dec[AW-1:0];
  assign right_src  = gap_end[AW-1:0];
  assign right_dst  = cur[AW-1:0];
  assign flush_addr = flush_full[AW-1:0];

endmodule

`default_nettype wire

[hw/rtl/cursor_line_edit_buffer.sv]
// top level of the cursor line edit buffer (gap buffer line editor)
//
// in_key carries key items: op 0 applies key_code at the cursor ('<' left,
// '>' right, '-' backspace, anything else inserts), op 1 flushes the line.
// out_char carries the flushed line one character per transfer, last marks
// the final one; an empty line gives a single transfer with char_valid 0.
// overflowed reports an insert dropped on a full line since the last flush.
// Text lives in a gap buffer memory of LINE_CAPACITY bytes with a registered
// read. Inserts, backspaces and blocked moves complete without leaving ST_IDLE;
// a cursor move is a read then a write of one character across the gap.
// A flush reads each character from memory, then loads it into the output
// register, and releases in_key once the last result is in the output
// register. When the receiver stalls the output register holds and the flush
// walk pauses; key edits after a flush go on while its last result waits.
// Synchronous reset empties the line; store contents stay undefined and are
// never read before being written.
`default_nettype none

module cursor_line_edit_buffer #(
  parameter int LINE_CAPACITY = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  clebuf_key_if.sink    in_key,
  clebuf_char_if.source out_char
);

  import clebuf_pkg::*;

  localparam int AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int CW = $clog2(LINE_CAPACITY + 1);

  logic [7:0]    mem [LINE_CAPACITY];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  clebuf_state_t state_r, state_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          ovf_r, ovf_nxt;
  logic          pend_r, pend_nxt;
  logic          dir_r, dir_nxt;
  logic [AW-1:0] dst_r, dst_nxt;
  char_item_t    out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          in_fire;
  logic          slot_free;
  logic          out_load;
  logic          flush_done;
  logic [AW-1:0] left_src, left_dst, right_src, right_dst, flush_addr;

  clebuf_gap_map #(.LINE_CAPACITY(LINE_CAPACITY)) u_gap_map (
    .len        (len_r),
    .cur        (cur_r),
    .idx        (idx_r),
    .left_src   (left_src),
    .left_dst   (left_dst),
    .right_src  (right_src),
    .right_dst  (right_dst),
    .flush_addr (flush_addr)
  );

  assign in_key.ready     = (state_r == ST_IDLE);
  assign in_fire          = in_key.valid && in_key.ready;
  assign slot_free        = !out_valid_r || out_char.ready;
  assign out_char.valid   = out_valid_r;
  assign out_char.payload = out_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      cur_r       <= '0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      idx_r       <= idx_nxt;
      ovf_r       <= ovf_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r <= dir_nxt;
    dst_r <= dst_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    ovf_nxt    = ovf_r;
    pend_nxt   = 1'b0;
    dir_nxt    = dir_r;
    dst_nxt    = dst_r;
    out_nxt    = out_r;
    out_load   = 1'b0;
    flush_done = 1'b0;
    mem_we     = 1'b0;
    mem_wa     = cur_r[AW-1:0];
    mem_wd     = in_key.payload.key_code;
    mem_re     = 1'b0;
    mem_ra     = flush_addr;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_key.payload.op == OP_FLUSH) begin
            state_nxt = ST_FLUSH;
            idx_nxt   = '0;
          end else begin
            case (in_key.payload.key_code)
              KEY_LEFT: begin
                if (cur_r != '0) begin
                  mem_re    = 1'b1;
                  mem_ra    = left_src;
                  dst_nxt   = left_dst;
                  dir_nxt   = 1'b0;
                  state_nxt = ST_MOVE;
                end
              end
              KEY_RIGHT: begin
                if (cur_r < len_r) begin
                  mem_re    = 1'b1;
                  mem_ra    = right_src;
                  dst_nxt   = right_dst;
                  dir_nxt   = 1'b1;
                  state_nxt = ST_MOVE;
                end
              end
              KEY_BACK: begin
                // the deleted character just falls into the gap
                if (cur_r != '0) begin
                  cur_nxt = cur_r - CW'(1);
                  len_nxt = len_r - CW'(1);
                end
              end
              default: begin
                if (len_r == CW'(LINE_CAPACITY)) begin
                  ovf_nxt = 1'b1;
                end else begin
                  mem_we  = 1'b1;
                  cur_nxt = cur_r + CW'(1);
                  len_nxt = len_r + CW'(1);
                end
              end
            endcase
          end
        end
      end

      ST_MOVE: begin
        // carry one character across the gap
        mem_we    = 1'b1;
        mem_wa    = dst_r;
        mem_wd    = rd_data_r;
        cur_nxt   = dir_r ? (cur_r + CW'(1)) : (cur_r - CW'(1));
        state_nxt = ST_IDLE;
      end

      ST_FLUSH: begin
        if (len_r == '0) begin
          if (slot_free) begin
            out_load   = 1'b1;
            out_nxt    = '{char_out: 8'h00, char_valid: 1'b0, last: 1'b1, overflowed: ovf_r};
            flush_done = 1'b1;
          end
        end else if (pend_r) begin
          // slot was reserved when the read went out
          out_load = 1'b1;
          out_nxt  = '{char_out: rd_data_r, char_valid: 1'b1,
                       last: (idx_r == len_r), overflowed: ovf_r};
          if (idx_r == len_r) begin
            flush_done = 1'b1;
          end
        end else if (slot_free) begin
          mem_re   = 1'b1;
          mem_ra   = flush_addr;
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end
        if (flush_done) begin
          len_nxt   = '0;
          cur_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_char.ready;
    end
  end

  property p_cursor_in_line;
    @(posedge clk) disable iff (!rst_n) cur_r <= len_r;
  endproperty
  a_cursor_in_line: assert property (p_cursor_in_line)
    else $error("cursor beyond end of line");

  property p_len_in_range;
    @(posedge clk) disable iff (!rst_n) len_r <= CW'(LINE_CAPACITY);
  endproperty
  a_len_in_range: assert property (p_len_in_range)
    else $error("line length beyond capacity");

  property p_read_slot_free;
    @(posedge clk) disable iff (!rst_n) pend_r |-> !out_valid_r;
  endproperty
  a_read_slot_free: assert property (p_read_slot_free)
    else $error("flush read returned into an occupied output register");

  property p_flush_clears;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_FLUSH && flush_done) |=> (len_r == '0 && cur_r == '0 && !ovf_r);
  endproperty
  a_flush_clears: assert property (p_flush_clears)
    else $error("line not cleared after flush");

endmodule

`default_nettype wire

[test/tb.sv]
// testbench for the cursor line edit buffer: directed and random key sessions
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clebuf_pkg::*;

  localparam int LINE_CAPACITY = 64;
  localparam int PHASE_ITEMS   = 50;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 50;

  logic clk;
  logic rst_n;

  clebuf_key_if  key_ch ();
  clebuf_char_if char_ch ();

  cursor_line_edit_buffer #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_key  (key_ch),
    .out_char(char_ch)
  );

  // line model: text before and after the cursor in one queue
  logic [7:0] line_text[$];
  int         cursor_pos;
  logic       overflow_seen;
  char_item_t expected_chars[$];

  int send_idle_pct;
  int recv_stall_pct;
  int keys_sent;
  int fail_count;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    char_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      char_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void apply_to_line(input key_item_t item);
    char_item_t c;
    int i;
    if (item.op == OP_FLUSH) begin
      if (line_text.size() == 0) begin
        c.char_out   = 8'h00;
        c.char_valid = 1'b0;
        c.last       = 1'b1;
        c.overflowed = overflow_seen;
        expected_chars = {expected_chars, c};
      end else begin
        for (i = 0; i < line_text.size(); i++) begin
          c.char_out   = line_text[i];
          c.char_valid = 1'b1;
          c.last       = (i == line_text.size() - 1);
          c.overflowed = overflow_seen;
          expected_chars = {expected_chars, c};
        end
      end
      line_text.delete();
      cursor_pos    = 0;
      overflow_seen = 1'b0;
    end else begin
      case (item.key_code)
        KEY_LEFT: begin
          if (cursor_pos > 0) cursor_pos--;
        end
        KEY_RIGHT: begin
          if (cursor_pos < line_text.size()) cursor_pos++;
        end
        KEY_BACK: begin
          if (cursor_pos > 0) begin
            line_text.delete(cursor_pos - 1);
            cursor_pos--;
          end
        end
        default: begin
          if (line_text.size() >= LINE_CAPACITY) begin
            overflow_seen = 1'b1;
          end else begin
            line_text.insert(cursor_pos, item.key_code);
            cursor_pos++;
          end
        end
      endcase
    end
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic send_key(input logic op, input logic [7:0] key);
    key_item_t item;
    item.op       = op;
    item.key_code = key;
    while ($urandom_range(99) < send_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(negedge clk);
    end
    key_ch.valid   <= 1'b1;
    key_ch.payload <= item;
    do @(posedge clk); while (!key_ch.ready);
    apply_to_line(item);
    keys_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    logic [7:0] k;
    do k = 8'($urandom_range(255));
    while (k == KEY_LEFT || k == KEY_RIGHT || k == KEY_BACK);
    return k;
  endfunction

  always @(posedge clk) begin : check_chars
    char_item_t got;
    char_item_t want;
    if (rst_n && char_ch.valid && char_ch.ready) begin
      got = char_ch.payload;
      if (expected_chars.size() == 0) begin
        note_failure($sformatf("unexpected char %h valid %b last %b ovf %b",
                               got.char_out, got.char_valid, got.last, got.overflowed));
      end else begin
        want = expected_chars.pop_front();
        if (got.char_out !== want.char_out || got.char_valid !== want.char_valid ||
            got.last !== want.last || got.overflowed !== want.overflowed)
          note_failure($sformatf(
            "exp char %h valid %b last %b ovf %b, got char %h valid %b last %b ovf %b",
            want.char_out, want.char_valid, want.last, want.overflowed,
            got.char_out, got.char_valid, got.last, got.overflowed));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (key_ch.valid && key_ch.ready) || (char_ch.valid && char_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("[cursor_line_edit_buffer] ERROR");
        $finish;
      end
    end
  end

  task automatic test_empty_flush();
    // key byte on a flush must be ignored
    send_key(OP_FLUSH, KEY_LEFT);
    send_key(OP_FLUSH, 8'hFF);
  endtask

  task automatic test_cursor_edges();
    send_key(OP_KEY, KEY_LEFT);
    send_key(OP_KEY, KEY_BACK);
    send_key(OP_KEY, KEY_RIGHT);
    send_key(OP_KEY, 8'h00);
    send_key(OP_KEY, 8'hFF);
    send_key(OP_KEY, 8'h41);
    send_key(OP_KEY, KEY_RIGHT);
    send_key(OP_KEY, KEY_LEFT);
    send_key(OP_KEY, KEY_LEFT);
    send_key(OP_KEY, 8'h42);
    send_key(OP_KEY, KEY_BACK);
    send_key(OP_KEY, KEY_BACK);
    send_key(OP_KEY, KEY_LEFT);
    send_key(OP_KEY, KEY_BACK);
    send_key(OP_KEY, KEY_RIGHT);
    send_key(OP_KEY, KEY_RIGHT);
    send_key(OP_FLUSH, 8'h41);
  endtask

  task automatic test_full_line();
    int i;
    for (i = 0; i < LINE_CAPACITY; i++) send_key(OP_KEY, text_byte());
    // both inserts land on a full line and are dropped
    send_key(OP_KEY, text_byte());
    send_key(OP_KEY, KEY_LEFT);
    send_key(OP_KEY, text_byte());
    send_key(OP_FLUSH, 8'h00);
    // overflow must have been cleared by the flush
    send_key(OP_FLUSH, 8'h2D);
  endtask

  task automatic short_line();
    int n;
    int i;
    int r;
    n = $urandom_range(0, 15);
    for (i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 55)      send_key(OP_KEY, text_byte());
      else if (r < 70) send_key(OP_KEY, KEY_LEFT);
      else if (r < 82) send_key(OP_KEY, KEY_RIGHT);
      else             send_key(OP_KEY, KEY_BACK);
    end
    send_key(OP_FLUSH, 8'($urandom_range(255)));
  endtask

  task automatic filled_line();
    int n;
    int i;
    n = $urandom_range(LINE_CAPACITY - 2, LINE_CAPACITY + 8);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) send_key(OP_KEY, KEY_LEFT);
      send_key(OP_KEY, text_byte());
    end
    // sometimes empty the line again so the overflow shows on an empty flush
    if ($urandom_range(1) == 1) begin
      while (cursor_pos < line_text.size()) send_key(OP_KEY, KEY_RIGHT);
      while (line_text.size() > 0) send_key(OP_KEY, KEY_BACK);
    end
    send_key(OP_FLUSH, 8'($urandom_range(255)));
  endtask

  task automatic random_phase(input int idle_pct, input int stall_pct);
    int start;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = keys_sent;
    while (keys_sent - start < PHASE_ITEMS) begin
      if ($urandom_range(11) == 0) filled_line();
      else                         short_line();
    end
  endtask

  task automatic test_random_lines();
    random_phase(0, 0);
    random_phase(45, 0);
    random_phase(0, 45);
    random_phase(31, 31);
  endtask

  initial begin
    rst_n          = 1'b0;
    key_ch.valid   = 1'b0;
    key_ch.payload = '0;
    cursor_pos     = 0;
    overflow_seen  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    keys_sent      = 0;
    fail_count     = 0;
    quiet_cycles   = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_flush();
    test_cursor_edges();
    test_full_line();
    test_random_lines();

    key_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && expected_chars.size() == 0) begin
      $display("[cursor_line_edit_buffer] OK");
    end else begin
      $display("[cursor_line_edit_buffer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/clebuf_pkg.sv
hw/rtl/clebuf_key_if.sv
hw/rtl/clebuf_char_if.sv
hw/rtl/clebuf_gap_map.sv
hw/rtl/cursor_line_edit_buffer.sv
test/tb.sv
